FILE: src/assert_macros.svh
// Assertion macros shared by the touch coordinate mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is held.
`define TCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also runs during reset.
`define TCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TCM_ASSERT(lbl, prop, msg)
`define TCM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/tcm_pkg.sv
// Shared types and constants of the touch coordinate mapper.
`default_nettype none
package tcm_pkg;

  localparam int RAW_BITS_DEF     = 15;
  localparam int SCREEN_BITS_DEF  = 13;
  localparam int FULL_SCALE_RESET = 100;
  localparam int STATE_BITS       = 16;
  localparam int KIND_BITS        = 2;
  localparam int CFG_IDX_BITS     = 3;
  localparam int ORIENT_BITS      = 3;

  localparam logic [STATE_BITS-1:0] ST_UP   = 16'd0;
  localparam logic [STATE_BITS-1:0] ST_DOWN = 16'd1;

  localparam logic [KIND_BITS-1:0] EV_MOVE = 2'd0;
  localparam logic [KIND_BITS-1:0] EV_DOWN = 2'd1;
  localparam logic [KIND_BITS-1:0] EV_UP   = 2'd2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ORIENT   = 3'd0,
    REG_X_OFFSET = 3'd1,
    REG_Y_OFFSET = 3'd2,
    REG_X_SPAN   = 3'd3,
    REG_Y_SPAN   = 3'd4,
    REG_SCREEN_W = 3'd5,
    REG_SCREEN_H = 3'd6
  } reg_idx_t;

  // Control from the top level to one axis unit.
  typedef struct packed {
    logic start;
    logic take;
    logic mirror;
  } axis_ctl_t;

endpackage
`default_nettype wire

FILE: src/tcm_axis.sv
// One axis: offset clamp, bit-serial multiply, restoring divide, saturate, mirror.
`default_nettype none
module tcm_axis import tcm_pkg::*; #(
  parameter int RAW_BITS    = RAW_BITS_DEF,
  parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire axis_ctl_t              ctl,
  input  wire logic [RAW_BITS-1:0]    raw,
  input  wire logic [RAW_BITS-1:0]    offset,
  input  wire logic [RAW_BITS-1:0]    span,
  input  wire logic [SCREEN_BITS-1:0] size,
  output logic                        done,
  output logic [SCREEN_BITS-1:0]      coord
);

  localparam int PW = RAW_BITS + SCREEN_BITS;
  localparam int CW = $clog2(PW);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIN  = 4'b1000
  } axis_state_t;

  axis_state_t            state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [PW-1:0]          prod_r, prod_nxt;
  logic [RAW_BITS-1:0]    rem_r, rem_nxt;
  logic [RAW_BITS-1:0]    d_r, d_nxt;
  logic [SCREEN_BITS-1:0] size_r, size_nxt;
  logic                   mirror_r, mirror_nxt;

  logic [RAW_BITS-1:0]    diff;
  logic [RAW_BITS:0]      mul_sum;
  logic [RAW_BITS:0]      trial;
  logic [RAW_BITS:0]      trial_sub;
  logic                   fits;
  logic [SCREEN_BITS-1:0] sat;

  assign diff      = (raw > offset) ? raw - offset : '0;
  // Shift-add: add the multiplicand to the upper half, then shift right.
  assign mul_sum   = {1'b0, prod_r[PW-1:SCREEN_BITS]} + (prod_r[0] ? {1'b0, d_r} : '0);
  assign trial     = {rem_r, prod_r[PW-1]};
  assign trial_sub = trial - {1'b0, span};
  assign fits      = (trial >= {1'b0, span});

  assign sat   = ((prod_r[PW-1:SCREEN_BITS] != '0) || (prod_r[SCREEN_BITS-1:0] > size_r)) ?
                 size_r : prod_r[SCREEN_BITS-1:0];
  assign coord = mirror_r ? size_r - sat : sat;
  assign done  = (state_r == A_FIN);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    rem_nxt    = rem_r;
    d_nxt      = d_r;
    size_nxt   = size_r;
    mirror_nxt = mirror_r;
    case (state_r)
      A_IDLE: begin
        if (ctl.start) begin
          d_nxt      = diff;
          size_nxt   = size;
          mirror_nxt = ctl.mirror;
          rem_nxt    = '0;
          cnt_nxt    = CW'(SCREEN_BITS - 1);
          prod_nxt   = {{RAW_BITS{1'b0}}, size};
          // zero span: result is the size itself, already in prod
          state_nxt  = (span == '0) ? A_FIN : A_MUL;
        end
      end
      A_MUL: begin
        prod_nxt = {mul_sum, prod_r[SCREEN_BITS-1:1]};
        if (cnt_r == '0) begin
          cnt_nxt   = CW'(PW - 1);
          state_nxt = A_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      A_DIV: begin
        rem_nxt  = fits ? trial_sub[RAW_BITS-1:0] : trial[RAW_BITS-1:0];
        prod_nxt = {prod_r[PW-2:0], fits};
        if (cnt_r == '0) begin
          state_nxt = A_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      A_FIN: begin
        if (ctl.take) begin
          state_nxt = A_IDLE;
        end
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    prod_r   <= prod_nxt;
    rem_r    <= rem_nxt;
    d_r      <= d_nxt;
    size_r   <= size_nxt;
    mirror_r <= mirror_nxt;
  end

endmodule
`default_nettype wire

FILE: src/touch_coordinate_mapper.sv
// Touch coordinate mapper: register file, report control and two axis units.
//
// Usage: a raw touch report enters on the in_ channel (valid/ready) with its
// state word and two raw readings. One pointer event leaves on the out_
// channel with the screen coordinates, except for an up report that follows
// an up report, which is taken and dropped without a result.
// The cfg_ channel writes the calibration registers by index; it is always
// ready, and writes to unused indexes are ignored. Write it only while idle.
// Both axes run in parallel, each through a bit-serial shift-add multiply
// and a restoring divide, then the result is loaded into the output
// register. A zero span skips both.
// Flow: one item at a time; the next item is taken the cycle after a result
// moves into the output register.
// Stall: the result holds on the out_ ports until out_ready; one further
// item may be taken and computed meanwhile, and then waits for the slot.
// Reset: synchronous, active low; spans reset to 100, other calibration
// registers to 0, and the block starts as if the last report had been an up.
`default_nettype none
`include "assert_macros.svh"
module touch_coordinate_mapper import tcm_pkg::*; #(
  parameter int RAW_BITS    = RAW_BITS_DEF,
  parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [STATE_BITS-1:0]   in_touch_state,
  input  wire logic [RAW_BITS-1:0]     in_raw_first,
  input  wire logic [RAW_BITS-1:0]     in_raw_second,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [KIND_BITS-1:0]         out_event_kind,
  output logic [SCREEN_BITS-1:0]       out_screen_x,
  output logic [SCREEN_BITS-1:0]       out_screen_y,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [((RAW_BITS > SCREEN_BITS) ? RAW_BITS : SCREEN_BITS)-1:0] cfg_data
);

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_BUSY = 2'b10
  } top_state_t;

  top_state_t             state_r, state_nxt;
  logic                   last_up_r, last_up_nxt;
  logic [KIND_BITS-1:0]   pend_kind_r, pend_kind_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [KIND_BITS-1:0]   out_kind_r;
  logic [SCREEN_BITS-1:0] out_x_r, out_y_r;

  logic [ORIENT_BITS-1:0] orient_r;
  logic [RAW_BITS-1:0]    x_off_r, y_off_r, x_span_r, y_span_r;
  logic [SCREEN_BITS-1:0] scr_w_r, scr_h_r;

  logic                   in_acc, drop, take;
  logic [RAW_BITS-1:0]    x_raw, y_raw;
  axis_ctl_t              x_ctl, y_ctl;
  logic                   x_done, y_done;
  logic [SCREEN_BITS-1:0] x_coord, y_coord;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == T_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign drop      = (in_touch_state == ST_UP) && last_up_r;
  assign x_raw     = orient_r[2] ? in_raw_second : in_raw_first;
  assign y_raw     = orient_r[2] ? in_raw_first  : in_raw_second;
  // result slot is free or being emptied this cycle
  assign take      = (state_r == T_BUSY) && x_done && y_done && (!out_valid_r || out_ready);

  assign x_ctl = '{start: in_acc && !drop, take: take, mirror: orient_r[0]};
  assign y_ctl = '{start: in_acc && !drop, take: take, mirror: !orient_r[1]};

  tcm_axis #(.RAW_BITS(RAW_BITS), .SCREEN_BITS(SCREEN_BITS)) u_axis_x (
    .clk(clk), .rst_n(rst_n), .ctl(x_ctl), .raw(x_raw), .offset(x_off_r),
    .span(x_span_r), .size(scr_w_r), .done(x_done), .coord(x_coord)
  );

  tcm_axis #(.RAW_BITS(RAW_BITS), .SCREEN_BITS(SCREEN_BITS)) u_axis_y (
    .clk(clk), .rst_n(rst_n), .ctl(y_ctl), .raw(y_raw), .offset(y_off_r),
    .span(y_span_r), .size(scr_h_r), .done(y_done), .coord(y_coord)
  );

  always_comb begin
    state_nxt     = state_r;
    last_up_nxt   = last_up_r;
    pend_kind_nxt = pend_kind_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      T_IDLE: begin
        if (in_acc && !drop) begin
          last_up_nxt = (in_touch_state == ST_UP);
          if (in_touch_state == ST_DOWN) begin
            pend_kind_nxt = EV_DOWN;
          end else if (in_touch_state == ST_UP) begin
            pend_kind_nxt = EV_UP;
          end else begin
            pend_kind_nxt = EV_MOVE;
          end
          state_nxt = T_BUSY;
        end
      end
      T_BUSY: begin
        if (take) begin
          out_valid_nxt = 1'b1;
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      last_up_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_up_r   <= last_up_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_kind_r <= pend_kind_nxt;
    if (take) begin
      out_kind_r <= pend_kind_r;
      out_x_r    <= x_coord;
      out_y_r    <= y_coord;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r <= '0;
      x_off_r  <= '0;
      y_off_r  <= '0;
      x_span_r <= RAW_BITS'(FULL_SCALE_RESET);
      y_span_r <= RAW_BITS'(FULL_SCALE_RESET);
      scr_w_r  <= '0;
      scr_h_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_ORIENT:   orient_r <= cfg_data[ORIENT_BITS-1:0];
        REG_X_OFFSET: x_off_r  <= cfg_data[RAW_BITS-1:0];
        REG_Y_OFFSET: y_off_r  <= cfg_data[RAW_BITS-1:0];
        REG_X_SPAN:   x_span_r <= cfg_data[RAW_BITS-1:0];
        REG_Y_SPAN:   y_span_r <= cfg_data[RAW_BITS-1:0];
        REG_SCREEN_W: scr_w_r  <= cfg_data[SCREEN_BITS-1:0];
        REG_SCREEN_H: scr_h_r  <= cfg_data[SCREEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_screen_x   = out_x_r;
  assign out_screen_y   = out_y_r;

  `TCM_ASSERT(a_take_fills_slot, take |=> out_valid_r, "result not loaded after take")
  `TCM_ASSERT(a_drop_repeat_up, (in_acc && drop) |=> (state_r == T_IDLE && last_up_r),
    "repeated up report started work")
  `TCM_ASSERT(a_start_goes_busy, (in_acc && !drop) |=> (state_r == T_BUSY),
    "accepted report did not start the axes")
  `TCM_ASSERT(a_axes_done_together_busy, (x_done || y_done) |-> (state_r == T_BUSY),
    "axis finished with no report in flight")

endmodule
`default_nettype wire

FILE: bench/tb_touch_coordinate_mapper.sv
// Self-checking testbench for the touch coordinate mapper: directed table, then random reports.
`timescale 1ns / 100ps

module tb_touch_coordinate_mapper;
  import tcm_pkg::*;

  localparam int RAW_W = RAW_BITS_DEF;
  localparam int SCR_W = SCREEN_BITS_DEF;
  localparam int CFG_W = (RAW_W > SCR_W) ? RAW_W : SCR_W;
  localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
  localparam int SCREEN_MAX = 4096;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  // Settle time after the queue empties, so a dropped up report has surely finished.
  localparam int DROP_SETTLE = 2 * (2 * SCR_W + RAW_W + 2);
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int TIMEOUT_NS = 30_000_000;

  typedef logic [RAW_W-1:0] raw_t;
  typedef logic [SCR_W-1:0] scr_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    scr_t x;
    scr_t y;
  } pointer_event_t;

  typedef struct {
    bit is_cfg;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [CFG_W-1:0] data;
    logic [STATE_BITS-1:0] st;
    raw_t a;
    raw_t b;
    bit typed;
    bit typed_has;
    pointer_event_t typed_ev;
  } directed_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [STATE_BITS-1:0] in_touch_state = '0;
  raw_t in_raw_first = '0;
  raw_t in_raw_second = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KIND_BITS-1:0] out_event_kind;
  scr_t out_screen_x;
  scr_t out_screen_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // calibration copy and report state
  logic [ORIENT_BITS-1:0] orient_cfg;
  raw_t x_off_cfg, y_off_cfg, x_span_cfg, y_span_cfg;
  scr_t scr_w_cfg, scr_h_cfg;
  bit prev_up;

  pointer_event_t expected_events[$];
  directed_step_t directed_steps[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit items_since_idle = 0;

  touch_coordinate_mapper #(
    .RAW_BITS(RAW_W),
    .SCREEN_BITS(SCR_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_touch_state(in_touch_state),
    .in_raw_first(in_raw_first),
    .in_raw_second(in_raw_second),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_event_kind(out_event_kind),
    .out_screen_x(out_screen_x),
    .out_screen_y(out_screen_y),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic scr_t scale_axis(input raw_t raw, input raw_t off, input raw_t span,
                                      input scr_t size);
    logic [31:0] d;
    logic [31:0] q;
    d = (raw > off) ? 32'(raw - off) : 32'd0;
    if (span == '0) return size;
    q = (d * 32'(size)) / 32'(span);
    if (q > 32'(size)) q = 32'(size);
    return q[SCR_W-1:0];
  endfunction

  // Returns 0 when the report is a repeated up and is dropped.
  function automatic bit map_report(input logic [STATE_BITS-1:0] st, input raw_t a,
                                    input raw_t b, output pointer_event_t ev);
    raw_t xr;
    raw_t yr;
    scr_t sx;
    scr_t sy;
    ev = '0;
    if (st == ST_UP && prev_up) return 1'b0;
    prev_up = (st == ST_UP);
    xr = orient_cfg[2] ? b : a;
    yr = orient_cfg[2] ? a : b;
    sx = scale_axis(xr, x_off_cfg, x_span_cfg, scr_w_cfg);
    sy = scale_axis(yr, y_off_cfg, y_span_cfg, scr_h_cfg);
    if (orient_cfg[0]) sx = scr_w_cfg - sx;
    if (!orient_cfg[1]) sy = scr_h_cfg - sy;
    if (st == ST_DOWN) ev.kind = EV_DOWN;
    else if (st == ST_UP) ev.kind = EV_UP;
    else ev.kind = EV_MOVE;
    ev.x = sx;
    ev.y = sy;
    return 1'b1;
  endfunction

  function automatic raw_t pick_raw_cfg();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return RAW_MAX;
    if (r <= 4) return raw_t'($urandom_range(1, 300));
    return raw_t'($urandom_range(0, RAW_MAX));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic add_cfg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_W-1:0] data);
    directed_step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    directed_steps.push_back(s);
  endtask

  task automatic add_item(input logic [STATE_BITS-1:0] st, input raw_t a, input raw_t b,
                          input bit typed, input bit has, input logic [KIND_BITS-1:0] kind,
                          input int x, input int y);
    directed_step_t s;
    s = '{default: '0};
    s.st = st;
    s.a = a;
    s.b = b;
    s.typed = typed;
    s.typed_has = has;
    s.typed_ev.kind = kind;
    s.typed_ev.x = scr_t'(x);
    s.typed_ev.y = scr_t'(y);
    directed_steps.push_back(s);
  endtask

  // Drops the last item off the input first, so it is not taken a second time.
  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  // Block must be idle before a register write; a dropped item leaves no trace in the queue.
  task automatic settle_idle();
    wait_results();
    if (items_since_idle) repeat (DROP_SETTLE) @(posedge clk);
    items_since_idle = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ORIENT:   orient_cfg = data[ORIENT_BITS-1:0];
      REG_X_OFFSET: x_off_cfg = data[RAW_W-1:0];
      REG_Y_OFFSET: y_off_cfg = data[RAW_W-1:0];
      REG_X_SPAN:   x_span_cfg = data[RAW_W-1:0];
      REG_Y_SPAN:   y_span_cfg = data[RAW_W-1:0];
      REG_SCREEN_W: scr_w_cfg = data[SCR_W-1:0];
      REG_SCREEN_H: scr_h_cfg = data[SCR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_report(input logic [STATE_BITS-1:0] st, input raw_t a, input raw_t b,
                             input bit typed, input bit typed_has,
                             input pointer_event_t typed_ev);
    int gap;
    bit has;
    pointer_event_t ev;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_touch_state <= st;
    in_raw_first <= a;
    in_raw_second <= b;
    do @(posedge clk); while (!in_ready);
    has = map_report(st, a, b, ev);
    if (typed) begin
      has = typed_has;
      ev = typed_ev;
    end
    if (has) expected_events.push_back(ev);
    items_since_idle = 1;
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    pointer_event_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("result with none pending: kind %0d x %0d y %0d",
                                  out_event_kind, out_screen_x, out_screen_y));
      end else begin
        want = expected_events.pop_front();
        if (out_event_kind !== want.kind)
          report_mismatch($sformatf("event_kind got %0d want %0d", out_event_kind, want.kind));
        if (out_screen_x !== want.x)
          report_mismatch($sformatf("screen_x got %0d want %0d", out_screen_x, want.x));
        if (out_screen_y !== want.y)
          report_mismatch($sformatf("screen_y got %0d want %0d", out_screen_y, want.y));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [STATE_BITS-1:0] st;
    raw_t a, b;
    int r;
    orient_cfg = '0;
    x_off_cfg = '0;
    y_off_cfg = '0;
    x_span_cfg = raw_t'(FULL_SCALE_RESET);
    y_span_cfg = raw_t'(FULL_SCALE_RESET);
    scr_w_cfg = '0;
    scr_h_cfg = '0;
    prev_up = 1'b1;

    // reset values: zero screen, so every coordinate is zero
    add_item(ST_UP, 0, 0, 1, 0, EV_MOVE, 0, 0);
    add_item(ST_DOWN, 50, 50, 1, 1, EV_DOWN, 0, 0);
    add_item(16'd2, RAW_MAX, 0, 1, 1, EV_MOVE, 0, 0);
    add_item(ST_UP, 0, 0, 1, 1, EV_UP, 0, 0);
    add_item(ST_UP, 9, 9, 1, 0, EV_MOVE, 0, 0);
    add_cfg(REG_SCREEN_W, CFG_W'(SCREEN_MAX));
    add_cfg(REG_SCREEN_H, CFG_W'(SCREEN_MAX));
    add_item(ST_DOWN, 100, 0, 1, 1, EV_DOWN, 4096, 4096);
    add_item(16'hFFFF, RAW_MAX, RAW_MAX, 1, 1, EV_MOVE, 4096, 0);
    add_item(16'd2, 50, 25, 1, 1, EV_MOVE, 2048, 3072);
    add_cfg(REG_ORIENT, 7);
    add_item(16'd3, 10, 75, 1, 1, EV_MOVE, 1024, 409);
    add_cfg(REG_X_OFFSET, 30);
    add_cfg(REG_Y_OFFSET, CFG_W'(RAW_MAX));
    add_item(16'h5555, 0, 40, 0, 0, EV_MOVE, 0, 0);
    // zero span takes the screen size
    add_cfg(REG_X_SPAN, 0);
    add_item(ST_UP, 123, 456, 1, 1, EV_UP, 0, 0);
    add_item(ST_UP, RAW_MAX, 0, 1, 0, EV_MOVE, 0, 0);
    add_cfg(REG_Y_SPAN, CFG_W'(RAW_MAX));
    add_cfg(REG_X_SPAN, 1);
    add_cfg(REG_X_OFFSET, 0);
    add_cfg(REG_Y_OFFSET, 0);
    add_cfg(REG_ORIENT, 0);
    add_item(ST_DOWN, 1, RAW_MAX, 1, 1, EV_DOWN, 4096, 0);
    add_item(16'h8000, RAW_MAX, 1, 0, 0, EV_MOVE, 0, 0);
    // bits above the register width are dropped
    add_cfg(REG_SCREEN_W, 15'h6000);
    add_cfg(REG_SCREEN_H, 15'h3000);
    add_cfg(REG_UNUSED, 15'h7FFF);
    add_cfg(REG_ORIENT, 15'h7FFA);
    add_item(16'd2, 100, 50, 0, 0, EV_MOVE, 0, 0);
    add_item(ST_DOWN, RAW_MAX, RAW_MAX, 0, 0, EV_MOVE, 0, 0);
    add_item(16'd4, 0, 0, 0, 0, EV_MOVE, 0, 0);
    add_item(ST_UP, 0, 0, 0, 0, EV_MOVE, 0, 0);
    add_item(16'hAAAA, 15'h2AAA, 15'h5555, 0, 0, EV_MOVE, 0, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        settle_idle();
        write_reg(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        send_report(directed_steps[i].st, directed_steps[i].a, directed_steps[i].b,
                    directed_steps[i].typed, directed_steps[i].typed_has,
                    directed_steps[i].typed_ev);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle_idle();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      write_reg(REG_ORIENT, CFG_W'($urandom_range(0, 7)));
      write_reg(REG_X_OFFSET, CFG_W'(pick_raw_cfg()));
      write_reg(REG_Y_OFFSET, CFG_W'(pick_raw_cfg()));
      write_reg(REG_X_SPAN, CFG_W'(pick_raw_cfg()));
      write_reg(REG_Y_SPAN, CFG_W'(pick_raw_cfg()));
      for (int k = 0; k < 2; k++) begin
        r = $urandom_range(0, 9);
        write_reg(k == 0 ? REG_SCREEN_W : REG_SCREEN_H,
                  (r == 0) ? CFG_W'(0) :
                  (r == 1) ? CFG_W'(SCREEN_MAX) :
                  (r == 2) ? (CFG_W'($urandom_range(0, SCREEN_MAX)) | (CFG_W'(3) << SCR_W)) :
                  CFG_W'($urandom_range(1, SCREEN_MAX)));
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold off until the pipeline is empty, then carry on
        if (phase == 1 && n == ITEMS_PER_PHASE / 2) wait_results();
        r = $urandom_range(0, 99);
        if (r < 15) st = ST_UP;
        else if (r < 30) st = ST_DOWN;
        else if (r < 35) st = STATE_BITS'($urandom);
        else st = STATE_BITS'($urandom_range(2, 16'hFFFF));
        r = $urandom_range(0, 9);
        a = (r == 0) ? '0 : (r == 1) ? RAW_MAX : (r == 2) ? raw_t'($urandom_range(0, 200)) :
            raw_t'($urandom);
        r = $urandom_range(0, 9);
        b = (r == 0) ? '0 : (r == 1) ? RAW_MAX : (r == 2) ? raw_t'($urandom_range(0, 200)) :
            raw_t'($urandom);
        send_report(st, a, b, 1'b0, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_results();
    repeat (DROP_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
